// File: rtl/spa_pkg.sv
`default_nettype none
package spa_pkg;

  localparam logic [1:0] OP_CLEAR      = 2'd0;
  localparam logic [1:0] OP_PLOT_ITEM  = 2'd1;
  localparam logic [1:0] OP_PLOT_FIXED = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  localparam logic [2:0] REG_X_BEGIN      = 3'd0;
  localparam logic [2:0] REG_X_SCALE      = 3'd1;
  localparam logic [2:0] REG_Y_BEGIN      = 3'd2;
  localparam logic [2:0] REG_Y_SCALE      = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
  localparam logic [2:0] REG_POINT_RADIUS = 3'd6;
  localparam logic [2:0] REG_FIXED_COLOR  = 3'd7;

  typedef struct packed {
    logic               start;
    logic signed [31:0] p;
    logic signed [31:0] b;
    logic signed [31:0] s;
  } map_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } div_rsp_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

  // premultiplied over for one channel
  function automatic logic [7:0] over8(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] sa);
    logic [15:0] m;
    m = 16'(sa) * 16'(d);
    return s + d - div255(m);
  endfunction

endpackage
`default_nettype wire

// File: rtl/spa_pixel_mem.sv
`default_nettype none
module spa_pixel_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/spa_mapper.sv
`default_nettype none
// trunc((p - b) * s / 2^32) with a 16 x 32 multiplier over 16-bit chunks of |p - b|
module spa_mapper (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spa_pkg::map_req_t req,
  output logic                  done,
  output logic signed [32:0]    coord
);

  logic        busy;
  logic [1:0]  step;
  logic        neg;
  logic [32:0] amag;
  logic [31:0] bmag;
  logic [63:0] acc;
  logic [15:0] chunk;
  logic [47:0] part;
  logic [63:0] part_sh;
  logic signed [32:0] diff;

  assign diff = {req.p[31], req.p} - {req.b[31], req.b};

  always_comb begin
    case (step)
      2'd0:    chunk = amag[15:0];
      2'd1:    chunk = amag[31:16];
      default: chunk = {15'b0, amag[32]};
    endcase
    part = 48'(chunk) * 48'(bmag);
    case (step)
      2'd0:    part_sh = {16'b0, part};
      2'd1:    part_sh = {part, 16'b0};
      default: part_sh = {part[31:0], 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
        acc  <= '0;
        neg  <= diff[32] ^ req.s[31];
        amag <= diff[32] ? 33'(-diff) : 33'(diff);
        bmag <= req.s[31] ? 32'(-req.s) : 32'(req.s);
      end else if (busy) begin
        acc  <= acc + part_sh;
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign coord = neg ? -$signed({1'b0, acc[63:32]}) : $signed({1'b0, acc[63:32]});

endmodule
`default_nettype wire

// File: rtl/spa_divider.sv
`default_nettype none
// c * 255 / alpha for three channels, saturated to 255, one quotient bit per cycle
module spa_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] pixel,
  output spa_pkg::div_rsp_t rsp
);

  logic       busy;
  logic       done;
  logic [2:0] cnt;
  logic [7:0] a;
  logic [7:0] rem [3];
  logic [7:0] low [3];
  logic [7:0] q   [3];
  logic       sat [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        a    <= pixel[31:24];
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic [7:0]  c;
      logic [15:0] n;
      logic [8:0]  r2;
      c  = pixel[8*k +: 8];
      n  = {c, 8'b0} - {8'b0, c};
      r2 = {rem[k], low[k][7]};
      if (start) begin
        sat[k] <= c >= pixel[31:24];
        rem[k] <= n[15:8];
        low[k] <= n[7:0];
        q[k]   <= '0;
      end else if (busy) begin
        low[k] <= {low[k][6:0], 1'b0};
        if (r2 >= {1'b0, a}) begin
          rem[k] <= 8'(r2 - {1'b0, a});
          q[k]   <= {q[k][6:0], 1'b1};
        end else begin
          rem[k] <= r2[7:0];
          q[k]   <= {q[k][6:0], 1'b0};
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.red   = sat[0] ? 8'hFF : q[0];
  assign rsp.green = sat[1] ? 8'hFF : q[1];
  assign rsp.blue  = sat[2] ? 8'hFF : q[2];

endmodule
`default_nettype wire

// File: rtl/scatter_point_alpha_rasterizer.sv
// Scatter point rasterizer into a premultiplied RGBA pixel store.
// Request channel (in_valid/in_ready) carries one opcode with its fields:
// clear, plot with the request colour, plot with fixed_color, or read.
// Only a read returns a result on the out_valid/out_ready channel.
// Configuration is a write port (cfg_we, cfg_index, cfg_data) taken at
// any edge with cfg_we high; write it only while the block is idle.
// A plot runs two coordinate mappings (3 multiply steps plus done each) on
// the shared mapper, then box setup, then a scan over every box position
// with a read-modify-write of each painted pixel on the single memory.
// A read: memory read, the 8-step un-premultiply divider, output load.
// A clear sweeps the store one word a cycle, MAX_WIDTH*MAX_HEIGHT words.
// After reset the same sweep runs with in_ready low; configuration
// writes are taken throughout.
// A result waits in the output register while the receiver stalls; the
// next request is accepted meanwhile, and a later read holds until the
// register frees.
`default_nettype none
module scatter_point_alpha_rasterizer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic [7:0]  color_red,
  input  wire logic [7:0]  color_green,
  input  wire logic [7:0]  color_blue,
  input  wire logic [7:0]  color_alpha,
  input  wire logic [7:0]  pixel_column,
  input  wire logic [7:0]  pixel_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RLIM  = MAX_RADIUS * 256;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MAPX  = 4'd2;
  localparam logic [3:0] S_MAPY  = 4'd3;
  localparam logic [3:0] S_SETUP = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_RDPIX = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // configuration registers
  logic signed [31:0] x_begin, x_scale, y_begin, y_scale;
  logic [8:0]  image_width, image_height;
  logic [13:0] point_radius;
  logic [31:0] fixed_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_begin      <= 32'sd0;
      x_scale      <= 32'sh0001_0000;
      y_begin      <= 32'sd0;
      y_scale      <= 32'shFFFF_0000;
      image_width  <= 9'd256;
      image_height <= 9'd256;
      point_radius <= 14'd0;
      fixed_color  <= 32'hFF00_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        spa_pkg::REG_X_BEGIN:      x_begin      <= cfg_data;
        spa_pkg::REG_X_SCALE:      x_scale      <= cfg_data;
        spa_pkg::REG_Y_BEGIN:      y_begin      <= cfg_data;
        spa_pkg::REG_Y_SCALE:      y_scale      <= cfg_data;
        spa_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        spa_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[8:0];
        spa_pkg::REG_POINT_RADIUS: point_radius <= cfg_data[13:0];
        spa_pkg::REG_FIXED_COLOR:  fixed_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes clipped to what the store holds, radius to MAX_RADIUS pixels
  logic [8:0]  w, h;
  logic [13:0] rsat;
  logic [27:0] rsq;
  logic [14:0] rup;
  assign w    = (32'(image_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width;
  assign h    = (32'(image_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : image_height;
  assign rsat = (32'(point_radius) > RLIM) ? 14'(RLIM) : point_radius;
  assign rsq  = 28'(rsat) * 28'(rsat);
  assign rup  = 15'(rsat) + 15'd255;

  logic [3:0]  state;
  logic [AW-1:0] clr_addr;
  logic          accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // per-request registers
  logic signed [31:0] py;
  logic [3:0][7:0]    src;
  logic               rd_inside;
  logic signed [32:0] cx, cy;
  logic [6:0]         cr;
  logic [11:0]        crsq;
  logic [8:0]         x, y, yb, xe, ye;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         pix_alpha;

  // source colour, premultiplied at accept
  logic [3:0][7:0] raw;
  logic [3:0][7:0] src_in;
  always_comb begin
    if (opcode == spa_pkg::OP_PLOT_ITEM) begin
      raw = {color_alpha, color_blue, color_green, color_red};
    end else begin
      raw = fixed_color;
    end
    src_in[3] = raw[3];
    for (int k = 0; k < 3; k++) begin
      src_in[k] = spa_pkg::div255(16'(raw[k]) * 16'(raw[3]));
    end
  end

  // shared coordinate mapper
  spa_pkg::map_req_t map_req;
  logic              map_done;
  logic signed [32:0] map_coord;
  always_comb begin
    map_req.start = (accept && (opcode == spa_pkg::OP_PLOT_ITEM ||
                                opcode == spa_pkg::OP_PLOT_FIXED)) ||
                    (state == S_MAPX && map_done);
    if (state == S_IDLE) begin
      map_req.p = point_x;
      map_req.b = x_begin;
      map_req.s = x_scale;
    end else begin
      map_req.p = py;
      map_req.b = y_begin;
      map_req.s = y_scale;
    end
  end

  spa_mapper u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .done  (map_done),
    .coord (map_coord)
  );

  // clipped box; a zero radius yields the single centre pixel or nothing
  logic signed [34:0] cx35, cy35, crs, ws, hs;
  logic signed [34:0] xb35, xe35, yb35, ye35, hix, hiy;
  logic               box_empty;
  always_comb begin
    cx35 = {{2{cx[32]}}, cx};
    cy35 = {{2{cy[32]}}, cy};
    crs  = {28'b0, cr};
    ws   = {26'b0, w};
    hs   = {26'b0, h};
    hix  = cx35 + crs + 35'sd1;
    hiy  = cy35 + crs + 35'sd1;
    xb35 = (cx35 <= crs) ? 35'sd0 : cx35 - crs;
    yb35 = (cy35 <= crs) ? 35'sd0 : cy35 - crs;
    xe35 = (hix >= ws) ? ws : hix;
    ye35 = (hiy >= hs) ? hs : hiy;
    box_empty = (xe35 <= xb35) || (ye35 <= yb35);
  end

  // distance test for the current box position
  logic signed [34:0] dxl, dyl;
  logic signed [8:0]  dx, dy;
  logic [18:0]        d2;
  logic               hit;
  logic               last_y, last_x;
  always_comb begin
    dxl    = {26'b0, x} - cx35;
    dyl    = {26'b0, y} - cy35;
    dx     = dxl[8:0];
    dy     = dyl[8:0];
    d2     = 19'(unsigned'(18'(dx * dx))) + 19'(unsigned'(18'(dy * dy)));
    hit    = d2 <= 19'(crsq);
    last_y = ({1'b0, y} + 10'd1) == {1'b0, ye};
    last_x = ({1'b0, x} + 10'd1) == {1'b0, xe};
  end

  logic [AW-1:0] pix_addr, rd_req_addr;
  assign pix_addr    = AW'(32'(y) * MAX_WIDTH + 32'(x));
  assign rd_req_addr = AW'(32'(pixel_row) * MAX_WIDTH + 32'(pixel_column));

  // pixel memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [31:0]   blended;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blended[8*k +: 8] = spa_pkg::over8(src[k], mem_rdata[8*k +: 8], src[3]);
    end
    mem_we    = (state == S_CLEAR) || (state == S_WR);
    mem_waddr = (state == S_CLEAR) ? clr_addr : wr_addr;
    mem_wdata = (state == S_CLEAR) ? 32'd0 : blended;
    mem_raddr = (state == S_IDLE) ? rd_req_addr : pix_addr;
  end

  spa_pixel_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // un-premultiply on reads
  logic               div_start;
  logic [31:0]        div_pixel;
  spa_pkg::div_rsp_t  div_rsp;
  assign div_pixel = rd_inside ? mem_rdata : 32'd0;
  assign div_start = (state == S_RDPIX);

  spa_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .pixel (div_pixel),
    .rsp   (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads this cycle
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            py        <= point_y;
            src       <= src_in;
            rd_inside <= (9'(pixel_column) < w) && (9'(pixel_row) < h);
            case (opcode)
              spa_pkg::OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              spa_pkg::OP_READ: state <= S_RDPIX;
              default:          state <= S_MAPX;
            endcase
          end
        end
        S_MAPX: begin
          cr   <= rup[14:8];
          crsq <= rsq[27:16];
          if (map_done) begin
            cx    <= map_coord;
            state <= S_MAPY;
          end
        end
        S_MAPY: begin
          if (map_done) begin
            cy    <= map_coord;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          x  <= xb35[8:0];
          y  <= yb35[8:0];
          yb <= yb35[8:0];
          xe <= xe35[8:0];
          ye <= ye35[8:0];
          state <= box_empty ? S_IDLE : S_SCAN;
        end
        S_SCAN, S_WR: begin
          // in scan: issue the read of a hit and wait for its write
          if (state == S_SCAN && hit) begin
            wr_addr <= pix_addr;
            state   <= S_WR;
          end else begin
            state <= S_SCAN;
            if (last_y) begin
              y <= yb;
              x <= x + 9'd1;
              if (last_x) begin
                state <= S_IDLE;
              end
            end else begin
              y <= y + 9'd1;
            end
          end
        end
        S_RDPIX: begin
          pix_alpha <= div_pixel[31:24];
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register frees
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_alpha <= pix_alpha;
            out_red   <= (pix_alpha == 8'd0) ? 8'd0 : div_rsp.red;
            out_green <= (pix_alpha == 8'd0) ? 8'd0 : div_rsp.green;
            out_blue  <= (pix_alpha == 8'd0) ? 8'd0 : div_rsp.blue;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/spa_checker.sv
`default_nettype none
module spa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] out_alpha
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("result changed while stalled");

  // store is swept after reset before any request
  a_rst_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during reset sweep");

  // requests are never accepted back to back
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back acceptance");

  // transparent pixel reads back as all zero
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_alpha == 8'd0 |-> out_red == 8'd0 && out_green == 8'd0
      && out_blue == 8'd0)
    else $error("colour on transparent pixel");

endmodule

bind scatter_point_alpha_rasterizer spa_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha)
);
`default_nettype wire

// File: tb/tb_scatter_point_alpha_rasterizer.sv
`default_nettype none
module tb_scatter_point_alpha_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int MAX_R = 32;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Shadow copy of the pixel store and the registers; predicts each read.
  class pixel_scoreboard;
    logic [31:0] store[MAX_W*MAX_H];
    logic [31:0] x_begin, x_scale, y_begin, y_scale, fixed_color;
    logic [8:0]  width, height;
    logic [13:0] radius;
    rgba_t       pending[$];
    int          errors;

    function new();
      foreach (store[i]) store[i] = '0;
      x_begin = '0;
      x_scale = 32'h0001_0000;
      y_begin = '0;
      y_scale = 32'hFFFF_0000;
      width = 9'd256;
      height = 9'd256;
      radius = '0;
      fixed_color = 32'hFF00_0000;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        spa_pkg::REG_X_BEGIN:      x_begin = v;
        spa_pkg::REG_X_SCALE:      x_scale = v;
        spa_pkg::REG_Y_BEGIN:      y_begin = v;
        spa_pkg::REG_Y_SCALE:      y_scale = v;
        spa_pkg::REG_IMAGE_WIDTH:  width = v[8:0];
        spa_pkg::REG_IMAGE_HEIGHT: height = v[8:0];
        spa_pkg::REG_POINT_RADIUS: radius = v[13:0];
        spa_pkg::REG_FIXED_COLOR:  fixed_color = v;
        default: ;
      endcase
    endfunction

    // trunc((p - b) * s) in Q16.16, wrapping like a 64-bit product
    function longint to_pixel(logic [31:0] p, logic [31:0] b, logic [31:0] s);
      longint prod;
      logic [63:0] mag;
      prod = (longint'($signed(p)) - longint'($signed(b))) * longint'($signed(s));
      if (prod >= 0) begin
        mag = prod;
        return longint'(mag >> 32);
      end
      mag = -prod;
      return -longint'(mag >> 32);
    endfunction

    function void blend(longint x, longint y, logic [31:0] src[4]);
      int idx;
      logic [31:0] d, n, dc;
      idx = int'(y) * MAX_W + int'(x);
      d = store[idx];
      n = '0;
      for (int k = 0; k < 4; k++) begin
        dc = (d >> (8 * k)) & 32'hFF;
        n |= ((src[k] + dc - (src[3] * dc) / 255) & 32'hFF) << (8 * k);
      end
      store[idx] = n;
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                               logic [31:0] item_color, logic [7:0] col,
                               logic [7:0] row);
      longint w, h, cx, cy, cr, crsq, xb, xe, yb, ye, dx, dy;
      logic [31:0] raw, pix, a, c, r;
      logic [31:0] src[4];
      rgba_t res;
      w = (width > MAX_W) ? MAX_W : width;
      h = (height > MAX_H) ? MAX_H : height;
      case (op)
        spa_pkg::OP_CLEAR: foreach (store[i]) store[i] = '0;
        spa_pkg::OP_READ: begin
          pix = '0;
          if (col < w && row < h) pix = store[int'(row) * MAX_W + int'(col)];
          a = pix >> 24;
          res = '0;
          if (a != 0) begin
            c = ((pix & 32'hFF) * 255) / a;
            res.red = (c > 255) ? 8'hFF : c[7:0];
            c = (((pix >> 8) & 32'hFF) * 255) / a;
            res.green = (c > 255) ? 8'hFF : c[7:0];
            c = (((pix >> 16) & 32'hFF) * 255) / a;
            res.blue = (c > 255) ? 8'hFF : c[7:0];
            res.alpha = a[7:0];
          end
          pending.push_back(res);
        end
        default: begin
          raw = (op == spa_pkg::OP_PLOT_ITEM) ? item_color : fixed_color;
          src[3] = raw >> 24;
          for (int k = 0; k < 3; k++) src[k] = (((raw >> (8 * k)) & 32'hFF) * src[3]) / 255;
          cx = to_pixel(px, x_begin, x_scale);
          cy = to_pixel(py, y_begin, y_scale);
          r = 32'(radius);
          if (r > MAX_R * 256) r = MAX_R * 256;
          if (r == 0) begin
            if (cx >= 0 && cx < w && cy >= 0 && cy < h) blend(cx, cy, src);
          end else begin
            cr = (r + 255) >> 8;
            crsq = (r * r) >> 16;
            xb = (cx <= cr) ? 0 : cx - cr;
            xe = (cx + cr + 1 >= w) ? w : cx + cr + 1;
            yb = (cy <= cr) ? 0 : cy - cr;
            ye = (cy + cr + 1 >= h) ? h : cy + cr + 1;
            for (longint x = xb; x < xe; x++)
              for (longint y = yb; y < ye; y++) begin
                dx = x - cx;
                dy = y - cy;
                if (dx * dx + dy * dy <= crsq) blend(x, y, src);
              end
          end
        end
      endcase
    endfunction

    task check_pixel(rgba_t got);
      rgba_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red)
        report($sformatf("red got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d want %0d", got.blue, want.blue));
      if (got.alpha !== want.alpha)
        report($sformatf("alpha got %0d want %0d", got.alpha, want.alpha));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = spa_pkg::OP_READ;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [7:0]  color_red = '0;
  logic [7:0]  color_green = '0;
  logic [7:0]  color_blue = '0;
  logic [7:0]  color_alpha = '0;
  logic [7:0]  pixel_column = '0;
  logic [7:0]  pixel_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = spa_pkg::REG_X_BEGIN;
  logic [31:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  bit  idle_on = 1'b1;
  int  settle = 200;
  int  cycle_count = 0;

  always #6 clk = ~clk;

  scatter_point_alpha_rasterizer i_dut (
    .clk, .rst, .in_valid, .in_ready, .opcode, .point_x, .point_y,
    .color_red, .color_green, .color_blue, .color_alpha, .pixel_column, .pixel_row,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue, .out_alpha,
    .cfg_we, .cfg_index, .cfg_data
  );

  // Watch both channels at the rising edge; every accepted request and
  // result goes straight into the scoreboard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(opcode, point_x, point_y,
                        {color_alpha, color_blue, color_green, color_red},
                        pixel_column, pixel_row);
      if (out_valid && out_ready)
        sb.check_pixel('{out_red, out_green, out_blue, out_alpha});
    end
  end

  // Result side: stall about 13 percent of the time unless idling is off.
  always @(negedge clk)
    out_ready <= !idle_on || ($urandom_range(0, 99) >= 13);

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drive one request; hold it until the block takes it.
  task automatic send_request(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                              logic [31:0] color, logic [7:0] col, logic [7:0] row);
    int cr;
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    point_x <= px;
    point_y <= py;
    {color_alpha, color_blue, color_green, color_red} <= color;
    pixel_column <= col;
    pixel_row <= row;
    do @(posedge clk); while (!in_ready);
    // Estimate how long the block may keep working on this one.
    cr = (int'(sb.radius > MAX_R * 256 ? MAX_R * 256 : sb.radius) + 255) >> 8;
    if (op == spa_pkg::OP_CLEAR) settle = MAX_W * MAX_H + 4000;
    else if ((op == spa_pkg::OP_PLOT_ITEM || op == spa_pkg::OP_PLOT_FIXED) && cr != 0)
      settle = (2 * cr + 1) * (2 * cr + 1) * 2 + 200;
    else settle = 200;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] xb, logic [31:0] xs, logic [31:0] yb,
                           logic [31:0] ys, logic [8:0] w, logic [8:0] h,
                           logic [13:0] r, logic [31:0] fc);
    write_reg(spa_pkg::REG_X_BEGIN, xb);
    write_reg(spa_pkg::REG_X_SCALE, xs);
    write_reg(spa_pkg::REG_Y_BEGIN, yb);
    write_reg(spa_pkg::REG_Y_SCALE, ys);
    write_reg(spa_pkg::REG_IMAGE_WIDTH, 32'(w));
    write_reg(spa_pkg::REG_IMAGE_HEIGHT, 32'(h));
    write_reg(spa_pkg::REG_POINT_RADIUS, 32'(r));
    write_reg(spa_pkg::REG_FIXED_COLOR, fc);
  endtask

  // Data coordinate that lands a few pixels around [0, extent) on one axis.
  function automatic logic [31:0] aim(logic [31:0] b, logic [31:0] s, int extent);
    longint t, tf;
    if (s == 0) return $urandom;
    t = longint'($urandom_range(0, extent + 8)) - 4;
    tf = t * 65536 + $urandom_range(0, 65535);
    return 32'(longint'($signed(b)) + (tf * 65536) / longint'($signed(s)));
  endfunction

  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 3))
      0: c[31:24] = 8'hFF;
      1: c[31:24] = 8'h00;
      default: ;
    endcase
    return c;
  endfunction

  // Mostly well-formed plots aimed at the image and reads of it, with
  // some noise coordinates to hit the clipping and skip paths.
  task automatic random_items(int count);
    int ext_w, ext_h, kind;
    logic [1:0] op;
    ext_w = (sb.width > MAX_W) ? MAX_W : sb.width;
    ext_h = (sb.height > MAX_H) ? MAX_H : sb.height;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      op = $urandom_range(0, 1) ? spa_pkg::OP_PLOT_ITEM : spa_pkg::OP_PLOT_FIXED;
      if (n == count / 2) drain();
      if (kind < 10)
        send_request($urandom_range(0, 2) == 0 ? spa_pkg::OP_READ : op, $urandom,
                     $urandom, $urandom, 8'($urandom), 8'($urandom));
      else if (kind < 62)
        send_request(op, aim(sb.x_begin, sb.x_scale, ext_w),
                     aim(sb.y_begin, sb.y_scale, ext_h), pick_color(), 8'($urandom),
                     8'($urandom));
      else if (kind < 90 && ext_w > 0 && ext_h > 0)
        send_request(spa_pkg::OP_READ, $urandom, $urandom, $urandom,
                     8'($urandom_range(0, ext_w - 1)), 8'($urandom_range(0, ext_h - 1)));
      else
        send_request(spa_pkg::OP_READ, $urandom, $urandom, $urandom, 8'($urandom),
                     8'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the reset settings: y maps through -1.0, so
    // pixel row r sits at data y = -r.
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd0, 8'd0);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'h0005_8000, 32'hFFFB_0000, 32'hFF32_64C8, '0, '0);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd5, 8'd5);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'h0005_0000, 32'hFFFB_0000, 32'h8000_FFFF, '0, '0);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd5, 8'd5);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'h0006_0000, 32'hFFFA_0000, 32'h00FF_FFFF, '0, '0);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd6, 8'd6);
    send_request(spa_pkg::OP_PLOT_FIXED, 32'h0007_0000, 32'hFFF9_0000, '0, '0, '0);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd7, 8'd7);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'hFFFF_8000, 32'hFFFF_8000, 32'h40FF_0000, '0, '0);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFF_FFFF, '0, '0);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'h0003_0000, 32'h0003_0000, 32'hFFFF_FFFF, '0, '0);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0, '0);
    send_request(spa_pkg::OP_PLOT_ITEM, 32'h00FF_E000, 32'hFF00_2000, 32'hC0A0_B0C0, '0, '0);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd255, 8'd255);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd0, 8'd0);
    send_request(spa_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    send_request(spa_pkg::OP_READ, '0, '0, '0, 8'd5, 8'd5);
    drain();

    // Phases, each with its own view of the data.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: configure('0, 32'h0001_0000, 32'h0100_0000, 32'hFFFF_0000, 9'd256, 9'd256,
                     14'd0, 32'hFF00_FF00);
        1: configure(32'hFFF0_0000, 32'h0002_0000, '0, 32'h0000_8000, 9'd1, 9'd1,
                     14'd0, $urandom);
        2: configure(32'h0000_4000, 32'h0001_0000, 32'h0008_0000, 32'hFFFF_0000, 9'd16,
                     9'd8, 14'd300, 32'h80FF_0000);
        3: configure($urandom_range(0, 1 << 20), 32'h0001_8000, 32'hFF80_0000,
                     32'hFFFF_8000, 9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                     14'($urandom_range(1, 1024)), $urandom);
        4: configure('0, 32'h0001_0000, '0, 32'h0001_0000, 9'd0, 9'd300, 14'd256, $urandom);
        5: configure('0, 32'h0001_0000, '0, 32'h0001_0000, 9'd511, 9'd511, 14'd8192,
                     32'h10FF_FFFF);
        6: configure(32'h0010_0000, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000, 9'd256,
                     9'd256, 14'd16383, $urandom);
        7: configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 9'd256,
                     9'd256, 14'd0, 32'hFFFF_FFFF);
        8: configure($urandom_range(0, 1 << 24), 32'h0000_4000, $urandom_range(0, 1 << 24),
                     32'hFFFF_C000, 9'd200, 9'd100, 14'($urandom_range(0, 600)), $urandom);
        default: configure($urandom, 32'($urandom_range(1 << 14, 1 << 18)), $urandom,
                           32'(-$urandom_range(1 << 14, 1 << 18)),
                           9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                           14'($urandom_range(0, 700)), $urandom);
      endcase
      // Run one phase with no idling on either side.
      idle_on = (phase != 8);
      if (phase == 3 || phase == 8) send_request(spa_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
      // Big discs scan large boxes, so keep those phases short.
      random_items((phase == 5 || phase == 6) ? 6 : 215);
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
